>>> design/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam int unsigned DigestWords = 8;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> design/sha256_if.sv
interface sha256_in_if;
  logic valid;
  logic ready;
  sha256_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
  logic valid;
  logic ready;
  sha256_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/sha256_byte_stream_hasher.sv
// Channel   Dir  Payload
// in_i      in   req_type, data_byte
// out_o     out  digest_word, word_index, last_word
//
// An append transfer that fills the block starts its compression, then a fold into
// the hash words: the shared round unit does one compression round per cycle.
// A finish transfer writes the pad bytes (64 minus the bytes held, and 64 more if a
// second block is needed) and compresses each padded block, then makes eight
// output transfers at one a cycle while the sink is ready.
// Reset clears control state and loads the initial hash words; the block
// takes no input while compressing, padding or emitting.
module sha256_byte_stream_hasher (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);
  import sha256_pkg::*;

  state_e state_q, state_d;
  // The block is held as sixteen big-endian words, one byte lane per position.
  word_t       buf_q [BlockBytes / 4];
  logic [5:0]  fill_q;
  logic [63:0] bytes_q;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [5:0]  rnd_q;
  logic [5:0]  pos_q;
  logic        pass2_q;  // finish: current padded block is the last one
  logic        pad_mark_done_q;
  logic [2:0]  idx_q;

  logic  acc;
  word_t w_new, t1, t2, s0, s1, ch, mj, ws0, ws1, w15, w2;
  logic [63:0] bits;
  logic [7:0]  pad_byte;

  assign acc = in_i.valid && in_i.ready;
  assign bits = {bytes_q[60:0], 3'b000};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_i.payload.req_type) state_d = ST_PAD;
          else if (fill_q == 6'd63) state_d = ST_ROUND;
        end
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
      ST_FOLD: begin
        // The first of two padded blocks goes back to padding for the second.
        if (pass2_q) state_d = ST_EMIT;
        else if (pad_mark_done_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_PAD:   if (pos_q == 6'd63) state_d = ST_ROUND;
      ST_EMIT:  if (out_o.ready && idx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    out_o.valid = (state_q == ST_EMIT);
    out_o.payload.digest_word = h_q[idx_q];
    out_o.payload.word_index = idx_q;
    out_o.payload.last_word = (idx_q == 3'd7);
  end

  // Pad byte at position pos_q; pass2_q set means length may go in.
  always_comb begin
    if (pos_q == fill_q && !pad_mark_done_q) pad_byte = PadMark;
    else if (pass2_q && pos_q >= 6'(LenOffset))
      pad_byte = bits[{~pos_q[2:0], 3'b111} -: 8];
    else pad_byte = 8'h00;
  end

  always_comb begin
    w15 = w_q[4'(rnd_q - 6'd15)];
    w2  = w_q[4'(rnd_q - 6'd2)];
    ws0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    ws1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    if (rnd_q < 6'd16)
      w_new = buf_q[rnd_q[3:0]];
    else
      w_new = w_q[4'(rnd_q - 6'd16)] + ws0 + w_q[4'(rnd_q - 6'd7)] + ws1;
    s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + RoundK[rnd_q] + w_new;
    s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && acc && !in_i.payload.req_type)
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_i.payload.data_byte;
    else if (state_q == ST_PAD)
      buf_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= pad_byte;
    if (state_q == ST_ROUND) begin
      w_q[rnd_q[3:0]] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      bytes_q <= '0;
      rnd_q <= '0;
      pos_q <= '0;
      pass2_q <= 1'b0;
      pad_mark_done_q <= 1'b0;
      idx_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          rnd_q <= '0;
          idx_q <= '0;
          if (acc) begin
            if (in_i.payload.req_type) begin
              pos_q <= fill_q;
              pad_mark_done_q <= 1'b0;
              // Length fits after the mark only if fewer than 56 bytes are held.
              pass2_q <= (fill_q < 6'(LenOffset));
            end else begin
              fill_q <= fill_q + 6'd1;
              bytes_q <= bytes_q + 64'd1;
              pass2_q <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          pad_mark_done_q <= 1'b1;
          pos_q <= pos_q + 6'd1;
        end
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          fill_q <= '0;
          if (!pass2_q && pad_mark_done_q) begin
            // First of two padded blocks: pad the second one from zero.
            pos_q <= '0;
            pass2_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_o.ready) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
              bytes_q <= '0;
              pad_mark_done_q <= 1'b0;
              pass2_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> bench/sha256_tb_checker.sv
module sha256_tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_in_if.sink   in_mon,
  sha256_out_if.sink  out_mon,
  output int          fail_count_o,
  output int          pending_o
);
  import sha256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  msg_bytes [64];
  int unsigned msg_fill;
  word_t       chain [8];
  logic [63:0] msg_len;
  out_item_t   digest_q [$];

  function automatic word_t ror(word_t x, int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  task automatic fold_block();
    word_t v [8];
    word_t w [64];
    word_t t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        w[i] = {msg_bytes[4*i], msg_bytes[4*i+1], msg_bytes[4*i+2], msg_bytes[4*i+3]};
      end else begin
        w[i] = w[i-16] + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    msg_fill = 0;
  endtask

  task automatic absorb(in_item_t it);
    logic [63:0] bits;
    int unsigned pos;
    out_item_t   o;
    if (!it.req_type) begin
      msg_bytes[msg_fill] = it.data_byte;
      msg_fill++;
      msg_len++;
      if (msg_fill == BlockBytes) fold_block();
    end else begin
      bits = msg_len << 3;
      pos = msg_fill;
      msg_bytes[pos] = PadMark;
      pos++;
      if (pos > LenOffset) begin
        while (pos < BlockBytes) begin
          msg_bytes[pos] = 8'h00;
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < LenOffset) begin
        msg_bytes[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) msg_bytes[LenOffset + i] = bits[63 - 8*i -: 8];
      fold_block();
      for (int i = 0; i < DigestWords; i++) begin
        o.digest_word = chain[i];
        o.word_index  = i[2:0];
        o.last_word   = (i == DigestWords - 1);
        digest_q.push_back(o);
      end
      for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
      msg_fill = 0;
      msg_len = '0;
    end
  endtask

  assign pending_o = digest_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_w;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
      msg_fill = 0;
      msg_len = '0;
      digest_q.delete();
      fail_count_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h (index %0d)", $time,
                   out_mon.payload.digest_word, out_mon.payload.word_index);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_mon.payload !== exp_w) begin
            $display("%0t: digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b", $time,
                     exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                     out_mon.payload.digest_word, out_mon.payload.word_index,
                     out_mon.payload.last_word);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) absorb(in_mon.payload);
    end
  end
endmodule

>>> bench/tb_top.sv
module tb_top;
  import sha256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  bit   long_hold = 1'b0;
  int   idle_cycles = 0;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  sha256_byte_stream_hasher DUT (.clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source));

  sha256_tb_checker u_checker (
    .clk_i, .rst_ni, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  // Sink stalls on its own pattern, with quiet stretches and one long hold-off.
  always @(negedge clk_i) begin
    int unsigned phase;
    phase = $urandom_range(0, 99);
    if (long_hold) out_ch.ready <= 1'b0;
    else if (($time / 2000) % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= (phase < 65);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic kind, logic [7:0] b);
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{req_type: kind, data_byte: b};
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_message(int unsigned len);
    int unsigned burst;
    burst = $urandom_range(1, 12);
    for (int unsigned i = 0; i < len; i++) begin
      send(1'b0, 8'($urandom_range(0, 255)));
      if (--burst == 0) begin
        if ($urandom_range(0, 1)) gap();
        burst = $urandom_range(1, 12);
      end
    end
    send(1'b1, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned sent, len;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty message, then a one-byte message of 00 and a two-byte message.
    send(1'b1, 8'hff);
    send(1'b0, 8'h00); send(1'b1, 8'h00);
    send(1'b0, 8'hff); send(1'b0, 8'h5a); send(1'b1, 8'ha5);
    drain();

    // 56 bytes need a second padded block; 64 bytes fill a block before the finish.
    for (int k = 0; k < 2; k++) begin
      len = (k == 0) ? 56 : 64;
      random_message(len);
    end
    drain();

    // Receiver holds off while messages keep coming, so the block backs up.
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      begin
        random_message(3);
        random_message(0);
        random_message(5);
      end
    join
    drain();

    sent = 0;
    while (sent < 15) begin
      len = $urandom_range(0, 9);
      random_message(len);
      sent += len + 1;
      if ($urandom_range(0, 2) == 0) gap();
    end
    drain();
    repeat (200) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
